// ===== hw/rtl/mailbox_receive_descriptor_queue_core_macros.svh =====
// assertion helpers used by the checker file mrdq_checker.sv
`ifndef MAILBOX_RECEIVE_DESCRIPTOR_QUEUE_CORE_MACROS_SVH
`define MAILBOX_RECEIVE_DESCRIPTOR_QUEUE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define MRDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define MRDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mrdq_pkg.sv =====
package mrdq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_POP   = 1'b1;

  localparam int STATUS_PENDING_BIT = 0;
  localparam int STATUS_ACK_BIT     = 8;

  localparam logic [15:0] ACK_LIMIT      = 16'h0080;
  localparam logic [7:0]  ACK_CODE_LOW   = 8'h31;
  localparam logic [7:0]  ACK_CODE_HIGH  = 8'hA2;
  localparam logic [31:0] DOORBELL_VALUE = 32'h0200_0000;
  localparam logic [31:0] STATUS_HI_MASK = 32'hFFFF_0000;
  localparam logic [7:0]  MSG_FRAME_A    = 8'h40;
  localparam logic [7:0]  MSG_FRAME_B    = 8'h41;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_POP   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    SEL_IN_STATUS  = 3'd0,
    SEL_OUT_PARAM  = 3'd1,
    SEL_OUT_STATUS = 3'd2,
    SEL_OUT_MSG    = 3'd3,
    SEL_DOORBELL   = 3'd4
  } sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELEASE,
    ST_ACK_P0,
    ST_ACK_STATUS,
    ST_ACK_MSG,
    ST_ACK_BELL,
    ST_DONE,
    ST_POP
  } state_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] incoming_status;
    logic [31:0] incoming_message;
    logic [31:0] param_word0;
    logic [31:0] param_word1;
    logic [31:0] param_word2;
    logic [31:0] param_word3;
    logic [31:0] param_word4;
    logic        outgoing_busy;
  } req_t;

  typedef struct packed {
    kind_t       result_kind;
    logic        last;
    sel_t        register_select;
    logic [31:0] write_data;
    logic        ok_flag;
    logic [15:0] out_tag;
    logic [7:0]  out_ring_index;
    logic [31:0] out_luma_dwords;
    logic [31:0] out_chroma_dwords;
    logic [31:0] out_chroma_bytes;
    logic [31:0] out_timestamp;
    logic [7:0]  out_task;
  } rsp_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  ring_index;
    logic [31:0] luma;
    logic [31:0] chroma_u;
    logic [31:0] chroma_bytes;
    logic [31:0] timestamp;
    logic [7:0]  task_num;
  } desc_t;

  typedef struct packed {
    logic   capture;
    logic   emit;
    state_t step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic req_pop;
    logic req_release;
    logic req_ack;
    logic item_ack;
  } stat_t;

endpackage

// ===== hw/rtl/mrdq_if.sv =====
interface mrdq_request_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] incoming_status;
  logic [31:0] incoming_message;
  logic [31:0] param_word0;
  logic [31:0] param_word1;
  logic [31:0] param_word2;
  logic [31:0] param_word3;
  logic [31:0] param_word4;
  logic        outgoing_busy;

  modport source (
    output valid, opcode, incoming_status, incoming_message, param_word0, param_word1,
           param_word2, param_word3, param_word4, outgoing_busy,
    input  ready
  );
  modport sink (
    input  valid, opcode, incoming_status, incoming_message, param_word0, param_word1,
           param_word2, param_word3, param_word4, outgoing_busy,
    output ready
  );
endinterface

interface mrdq_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic        last;
  logic [2:0]  register_select;
  logic [31:0] write_data;
  logic        ok_flag;
  logic [15:0] out_tag;
  logic [7:0]  out_ring_index;
  logic [31:0] out_luma_dwords;
  logic [31:0] out_chroma_dwords;
  logic [31:0] out_chroma_bytes;
  logic [31:0] out_timestamp;
  logic [7:0]  out_task;

  modport source (
    output valid, result_kind, last, register_select, write_data, ok_flag, out_tag,
           out_ring_index, out_luma_dwords, out_chroma_dwords, out_chroma_bytes,
           out_timestamp, out_task,
    input  ready
  );
  modport sink (
    input  valid, result_kind, last, register_select, write_data, ok_flag, out_tag,
           out_ring_index, out_luma_dwords, out_chroma_dwords, out_chroma_bytes,
           out_timestamp, out_task,
    output ready
  );
endinterface

// ===== hw/rtl/mrdq_ram.sv =====
module mrdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mrdq_ctrl.sv =====
module mrdq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mrdq_pkg::stat_t stat,
  output mrdq_pkg::cmd_t  cmd
);
  import mrdq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          priority if (stat.req_pop) state_next = ST_POP;
          else if (stat.req_release) state_next = ST_RELEASE;
          else if (stat.req_ack)     state_next = ST_ACK_P0;
          else                       state_next = ST_DONE;
        end
      end
      ST_RELEASE: begin
        if (stat.out_free) state_next = stat.item_ack ? ST_ACK_P0 : ST_DONE;
      end
      ST_ACK_P0:     if (stat.out_free) state_next = ST_ACK_STATUS;
      ST_ACK_STATUS: if (stat.out_free) state_next = ST_ACK_MSG;
      ST_ACK_MSG:    if (stat.out_free) state_next = ST_ACK_BELL;
      ST_ACK_BELL:   if (stat.out_free) state_next = ST_DONE;
      ST_DONE:       if (stat.out_free) state_next = ST_IDLE;
      ST_POP:        if (stat.out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = (state == ST_IDLE);
    cmd.capture = (state == ST_IDLE) && req_valid;
    cmd.emit    = (state != ST_IDLE) && stat.out_free;
    cmd.step    = state;
  end

endmodule

// ===== hw/rtl/mrdq_datapath.sv =====
module mrdq_datapath (
  input  logic            clk,
  input  logic            rst,
  input  mrdq_pkg::req_t  req,
  input  mrdq_pkg::cmd_t  cmd,
  output mrdq_pkg::stat_t stat,
  input  logic            rsp_ready,
  output logic            rsp_valid,
  output mrdq_pkg::rsp_t  rsp
);
  import mrdq_pkg::*;

  req_t             item;
  rsp_t             rsp_next;
  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] read_pointer;
  logic [CNT_W-1:0] fill_count;
  logic [31:0]      frame_counter;
  logic [31:0]      overflow_counter;
  desc_t            wdesc;
  desc_t            rdesc;
  logic [7:0]       task_num;
  logic [7:0]       ack_code;
  logic             is_frame;
  logic             full;
  logic             empty;
  logic             push;
  logic             pop;
  logic             drop;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req;
    end
  end

  assign task_num = item.incoming_message[23:16];
  assign ack_code = (item.incoming_message[15:0] < ACK_LIMIT) ? ACK_CODE_LOW : ACK_CODE_HIGH;
  assign is_frame = (item.incoming_message[7:0] == MSG_FRAME_A) ||
                    (item.incoming_message[7:0] == MSG_FRAME_B);
  assign full     = (fill_count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (fill_count == '0);

  assign push = cmd.emit && (cmd.step == ST_DONE) && is_frame && !full;
  assign drop = cmd.emit && (cmd.step == ST_DONE) && is_frame && full;
  assign pop  = cmd.emit && (cmd.step == ST_POP) && !empty;

  always_comb begin
    stat.out_free    = !rsp_valid || rsp_ready;
    stat.req_pop     = (req.opcode == OP_POP);
    stat.req_release = req.incoming_status[STATUS_PENDING_BIT];
    stat.req_ack     = req.incoming_status[STATUS_ACK_BIT] && !req.outgoing_busy;
    stat.item_ack    = item.incoming_status[STATUS_ACK_BIT] && !item.outgoing_busy;
  end

  always_comb begin
    wdesc.tag          = item.param_word0[15:0];
    wdesc.ring_index   = item.param_word0[31:24];
    wdesc.luma         = item.param_word1;
    wdesc.chroma_u     = item.param_word2;
    wdesc.chroma_bytes = item.param_word3;
    wdesc.timestamp    = item.param_word4;
    wdesc.task_num     = task_num;
  end

  mrdq_ram #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (write_pointer),
    .wdata (wdesc),
    .raddr (read_pointer),
    .rdata (rdesc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer    <= '0;
      read_pointer     <= '0;
      fill_count       <= '0;
      frame_counter    <= '0;
      overflow_counter <= '0;
    end else begin
      if (cmd.emit && (cmd.step == ST_DONE) && is_frame) begin
        frame_counter <= frame_counter + 32'd1;
      end
      if (drop) begin
        overflow_counter <= overflow_counter + 32'd1;
      end
      if (push) begin
        write_pointer <= (write_pointer == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : write_pointer + 1'b1;
        fill_count    <= fill_count + 1'b1;
      end
      if (pop) begin
        read_pointer <= (read_pointer == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : read_pointer + 1'b1;
        fill_count   <= fill_count - 1'b1;
      end
    end
  end

  always_comb begin
    rsp_next = '0;
    unique case (cmd.step)
      ST_RELEASE: begin
        rsp_next.result_kind     = KIND_WRITE;
        rsp_next.register_select = SEL_IN_STATUS;
        rsp_next.write_data      = {item.incoming_status[31:1], 1'b0};
      end
      ST_ACK_P0: begin
        rsp_next.result_kind     = KIND_WRITE;
        rsp_next.register_select = SEL_OUT_PARAM;
      end
      ST_ACK_STATUS: begin
        rsp_next.result_kind     = KIND_WRITE;
        rsp_next.register_select = SEL_OUT_STATUS;
        rsp_next.write_data      = (item.incoming_message & STATUS_HI_MASK) | 32'd1;
      end
      ST_ACK_MSG: begin
        rsp_next.result_kind     = KIND_WRITE;
        rsp_next.register_select = SEL_OUT_MSG;
        rsp_next.write_data      = {8'h00, task_num, 8'h00, ack_code};
      end
      ST_ACK_BELL: begin
        rsp_next.result_kind     = KIND_WRITE;
        rsp_next.register_select = SEL_DOORBELL;
        rsp_next.write_data      = DOORBELL_VALUE;
      end
      ST_DONE: begin
        // counter value after this event
        rsp_next.result_kind = KIND_DONE;
        rsp_next.last        = 1'b1;
        rsp_next.write_data  = overflow_counter + {31'd0, is_frame && full};
        rsp_next.ok_flag     = is_frame && !full;
      end
      ST_POP: begin
        rsp_next.result_kind = KIND_POP;
        rsp_next.last        = 1'b1;
        if (!empty) begin
          rsp_next.ok_flag           = 1'b1;
          rsp_next.out_tag           = rdesc.tag;
          rsp_next.out_ring_index    = rdesc.ring_index;
          rsp_next.out_luma_dwords   = rdesc.luma;
          rsp_next.out_chroma_dwords = rdesc.chroma_u;
          rsp_next.out_chroma_bytes  = rdesc.chroma_bytes;
          rsp_next.out_timestamp     = rdesc.timestamp;
          rsp_next.out_task          = rdesc.task_num;
        end
      end
      ST_IDLE: begin
        rsp_next = '0;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== hw/rtl/mailbox_receive_descriptor_queue_core.sv =====
// channel  | modport | carries
// ---------+---------+--------------------------------------------------
// request  | sink    | mailbox event or pop, one request at a time
// result   | source  | register writes, event done, pop answer
//
// a mailbox event is accepted in idle and then gives 1 to 6 results; a pop is
// accepted the same way and gives one result
// the controller emits one result per cycle into the single output register, but
// a stalled result holds the controller in its state; the next request is taken
// once the final result sits in the output register
// synchronous reset clears state, pointers, fill count and counters; descriptor
// storage is not cleared
module mailbox_receive_descriptor_queue_core (
  input logic            clk,
  input logic            rst,
  mrdq_request_if.sink   request,
  mrdq_result_if.source  result
);
  import mrdq_pkg::*;

  req_t  req;
  rsp_t  rsp;
  cmd_t  cmd;
  stat_t stat;
  logic  rsp_valid;
  logic  req_ready;

  always_comb begin
    req.opcode           = request.opcode;
    req.incoming_status  = request.incoming_status;
    req.incoming_message = request.incoming_message;
    req.param_word0      = request.param_word0;
    req.param_word1      = request.param_word1;
    req.param_word2      = request.param_word2;
    req.param_word3      = request.param_word3;
    req.param_word4      = request.param_word4;
    req.outgoing_busy    = request.outgoing_busy;
  end

  assign request.ready = req_ready;

  mrdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mrdq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_ready (result.ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  assign result.valid             = rsp_valid;
  assign result.result_kind       = rsp.result_kind;
  assign result.last              = rsp.last;
  assign result.register_select   = rsp.register_select;
  assign result.write_data        = rsp.write_data;
  assign result.ok_flag           = rsp.ok_flag;
  assign result.out_tag           = rsp.out_tag;
  assign result.out_ring_index    = rsp.out_ring_index;
  assign result.out_luma_dwords   = rsp.out_luma_dwords;
  assign result.out_chroma_dwords = rsp.out_chroma_dwords;
  assign result.out_chroma_bytes  = rsp.out_chroma_bytes;
  assign result.out_timestamp     = rsp.out_timestamp;
  assign result.out_task          = rsp.out_task;

endmodule

// ===== hw/rtl/mrdq_checker.sv =====
`include "mailbox_receive_descriptor_queue_core_macros.svh"

module mrdq_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_kind,
  input logic        rsp_last,
  input logic [31:0] rsp_data,
  input logic        rsp_ok,
  input logic [15:0] rsp_tag,
  input logic [31:0] rsp_luma
);
  import mrdq_pkg::*;

  // stalled result keeps its contents
  `MRDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_data) && $stable(rsp_last), "result changed while stalled")

  // one request at a time
  `MRDQ_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

  // idle only with nothing pending or the closing result waiting
  `MRDQ_ASSERT_NOW(a_idle_after_last, req_ready, !rsp_valid || rsp_last, "ready before closing result")

  `MRDQ_ASSERT_NOW(a_write_not_last, rsp_valid && rsp_kind == KIND_WRITE, !rsp_last && !rsp_ok && rsp_tag == 16'd0, "register write marked closing")

  `MRDQ_ASSERT_NOW(a_empty_pop_zero, rsp_valid && rsp_kind == KIND_POP && !rsp_ok, rsp_tag == 16'd0 && rsp_luma == 32'd0 && rsp_data == 32'd0, "empty pop carries data")

endmodule

bind mailbox_receive_descriptor_queue_core mrdq_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (request.valid),
  .req_ready (request.ready),
  .rsp_valid (result.valid),
  .rsp_ready (result.ready),
  .rsp_kind  (result.result_kind),
  .rsp_last  (result.last),
  .rsp_data  (result.write_data),
  .rsp_ok    (result.ok_flag),
  .rsp_tag   (result.out_tag),
  .rsp_luma  (result.out_luma_dwords)
);
